// ===== rtl/utf8vg_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8vg_pkg
// Shared types, constants and glyph tables for the UTF-8 glyph decoder.
// ----------------------------------------------------------------------------
package utf8vg_pkg;

  localparam int unsigned QueueDepthDefault = 4;
  localparam logic [3:0]  PitchReset        = 4'd6;

  // diacritic bits
  localparam logic [8:0] MK_NONE = 9'h000;
  localparam logic [8:0] MK_AC   = 9'h001;
  localparam logic [8:0] MK_GR   = 9'h002;
  localparam logic [8:0] MK_HK   = 9'h004;
  localparam logic [8:0] MK_TI   = 9'h008;
  localparam logic [8:0] MK_DT   = 9'h010;
  localparam logic [8:0] MK_CI   = 9'h020;
  localparam logic [8:0] MK_BR   = 9'h040;
  localparam logic [8:0] MK_HO   = 9'h080;
  localparam logic [8:0] MK_DB   = 9'h100;

  localparam logic [6:0] CH_A    = 7'h41;
  localparam logic [6:0] CH_D    = 7'h44;
  localparam logic [6:0] CH_E    = 7'h45;
  localparam logic [6:0] CH_I    = 7'h49;
  localparam logic [6:0] CH_O    = 7'h4F;
  localparam logic [6:0] CH_U    = 7'h55;
  localparam logic [6:0] CH_Y    = 7'h59;
  localparam logic [6:0] CH_QM   = 7'h3F;
  localparam logic [6:0] CH_NUL  = 7'h00;
  localparam logic [6:0] LOWER   = 7'h20;

  localparam logic [15:0] CP_QM  = 16'h003F;
  localparam logic [15:0] SAT16  = 16'hFFFF;

  typedef struct packed {
    logic [6:0] base;
    logic [8:0] marks;
  } glyph_t;

  // one queued word: a code point, last-of-string flag, and a flag for the
  // cut-short three-byte case, which yields a '?' ahead of the code point
  typedef struct packed {
    logic [15:0] cp;
    logic        last;
    logic        dbl;
  } entry_t;

  function automatic glyph_t latin_lookup(input logic [4:0] idx);
    glyph_t g;
    g = '{base: CH_NUL, marks: MK_NONE};
    unique case (idx)
      5'd0:  g = '{base: CH_A, marks: MK_GR};
      5'd1:  g = '{base: CH_A, marks: MK_AC};
      5'd2:  g = '{base: CH_A, marks: MK_CI};
      5'd3:  g = '{base: CH_A, marks: MK_TI};
      5'd8:  g = '{base: CH_E, marks: MK_GR};
      5'd9:  g = '{base: CH_E, marks: MK_AC};
      5'd10: g = '{base: CH_E, marks: MK_CI};
      5'd12: g = '{base: CH_I, marks: MK_GR};
      5'd13: g = '{base: CH_I, marks: MK_AC};
      5'd18: g = '{base: CH_O, marks: MK_GR};
      5'd19: g = '{base: CH_O, marks: MK_AC};
      5'd20: g = '{base: CH_O, marks: MK_CI};
      5'd21: g = '{base: CH_O, marks: MK_TI};
      5'd25: g = '{base: CH_U, marks: MK_GR};
      5'd26: g = '{base: CH_U, marks: MK_AC};
      5'd29: g = '{base: CH_Y, marks: MK_AC};
      default: g = '{base: CH_NUL, marks: MK_NONE};
    endcase
    return g;
  endfunction

  function automatic glyph_t viet_lookup(input logic [6:0] idx);
    glyph_t g;
    g = '{base: CH_QM, marks: MK_NONE};
    unique case (idx)
      7'd0:  g = '{base: CH_A, marks: MK_DT};
      7'd1:  g = '{base: CH_A, marks: MK_HK};
      7'd2:  g = '{base: CH_A, marks: MK_CI | MK_AC};
      7'd3:  g = '{base: CH_A, marks: MK_CI | MK_GR};
      7'd4:  g = '{base: CH_A, marks: MK_CI | MK_HK};
      7'd5:  g = '{base: CH_A, marks: MK_CI | MK_TI};
      7'd6:  g = '{base: CH_A, marks: MK_CI | MK_DT};
      7'd7:  g = '{base: CH_A, marks: MK_BR | MK_AC};
      7'd8:  g = '{base: CH_A, marks: MK_BR | MK_GR};
      7'd9:  g = '{base: CH_A, marks: MK_BR | MK_HK};
      7'd10: g = '{base: CH_A, marks: MK_BR | MK_TI};
      7'd11: g = '{base: CH_A, marks: MK_BR | MK_DT};
      7'd12: g = '{base: CH_E, marks: MK_DT};
      7'd13: g = '{base: CH_E, marks: MK_HK};
      7'd14: g = '{base: CH_E, marks: MK_TI};
      7'd15: g = '{base: CH_E, marks: MK_CI | MK_AC};
      7'd16: g = '{base: CH_E, marks: MK_CI | MK_GR};
      7'd17: g = '{base: CH_E, marks: MK_CI | MK_HK};
      7'd18: g = '{base: CH_E, marks: MK_CI | MK_TI};
      7'd19: g = '{base: CH_E, marks: MK_CI | MK_DT};
      7'd20: g = '{base: CH_I, marks: MK_HK};
      7'd21: g = '{base: CH_I, marks: MK_DT};
      7'd22: g = '{base: CH_O, marks: MK_DT};
      7'd23: g = '{base: CH_O, marks: MK_HK};
      7'd24: g = '{base: CH_O, marks: MK_CI | MK_AC};
      7'd25: g = '{base: CH_O, marks: MK_CI | MK_GR};
      7'd26: g = '{base: CH_O, marks: MK_CI | MK_HK};
      7'd27: g = '{base: CH_O, marks: MK_CI | MK_TI};
      7'd28: g = '{base: CH_O, marks: MK_CI | MK_DT};
      7'd29: g = '{base: CH_O, marks: MK_HO | MK_AC};
      7'd30: g = '{base: CH_O, marks: MK_HO | MK_GR};
      7'd31: g = '{base: CH_O, marks: MK_HO | MK_HK};
      7'd32: g = '{base: CH_O, marks: MK_HO | MK_TI};
      7'd33: g = '{base: CH_O, marks: MK_HO | MK_DT};
      7'd34: g = '{base: CH_U, marks: MK_DT};
      7'd35: g = '{base: CH_U, marks: MK_HK};
      7'd36: g = '{base: CH_U, marks: MK_HO | MK_AC};
      7'd37: g = '{base: CH_U, marks: MK_HO | MK_GR};
      7'd38: g = '{base: CH_U, marks: MK_HO | MK_HK};
      7'd39: g = '{base: CH_U, marks: MK_HO | MK_TI};
      7'd40: g = '{base: CH_U, marks: MK_HO | MK_DT};
      7'd41: g = '{base: CH_Y, marks: MK_GR};
      7'd42: g = '{base: CH_Y, marks: MK_DT};
      7'd43: g = '{base: CH_Y, marks: MK_HK};
      7'd44: g = '{base: CH_Y, marks: MK_TI};
      default: g = '{base: CH_QM, marks: MK_NONE};
    endcase
    return g;
  endfunction

  function automatic glyph_t map_cp(input logic [15:0] cp);
    glyph_t g;
    glyph_t t;
    g = '{base: CH_QM, marks: MK_NONE};
    t = '{base: CH_NUL, marks: MK_NONE};
    if (cp < 16'h0080) begin
      g.base = cp[6:0];
    end else if (cp[15:8] == 8'h00 && cp[7:6] == 2'b11) begin
      t = latin_lookup(cp[4:0]);
      if (t.base != CH_NUL) begin
        g.base  = cp[5] ? (t.base | LOWER) : t.base;
        g.marks = t.marks;
      end
    end else if (cp >= 16'h1EA0 && cp <= 16'h1EF9) begin
      t = viet_lookup(cp[7:1] - 7'h50);
      g.base  = cp[0] ? (t.base | LOWER) : t.base;
      g.marks = t.marks;
    end else begin
      unique case (cp)
        16'h0102: g = '{base: CH_A,         marks: MK_BR};
        16'h0103: g = '{base: CH_A | LOWER, marks: MK_BR};
        16'h0110: g = '{base: CH_D,         marks: MK_DB};
        16'h0111: g = '{base: CH_D | LOWER, marks: MK_DB};
        16'h0128: g = '{base: CH_I,         marks: MK_TI};
        16'h0129: g = '{base: CH_I | LOWER, marks: MK_TI};
        16'h0168: g = '{base: CH_U,         marks: MK_TI};
        16'h0169: g = '{base: CH_U | LOWER, marks: MK_TI};
        16'h01A0: g = '{base: CH_O,         marks: MK_HO};
        16'h01A1: g = '{base: CH_O | LOWER, marks: MK_HO};
        16'h01AF: g = '{base: CH_U,         marks: MK_HO};
        16'h01B0: g = '{base: CH_U | LOWER, marks: MK_HO};
        default:  g = '{base: CH_QM,        marks: MK_NONE};
      endcase
    end
    return g;
  endfunction

  function automatic logic [15:0] sat_mul(input logic [15:0] count, input logic [3:0] pitch);
    logic [19:0] p;
    p = count * pitch;
    return (|p[19:16]) ? SAT16 : p[15:0];
  endfunction

endpackage

// ===== rtl/utf8vg_front.sv =====
// ----------------------------------------------------------------------------
// utf8vg_front
// Byte classifier: assembles multi-byte sequences and queues code points.
// ----------------------------------------------------------------------------
module utf8vg_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [7:0]            text_byte,
  input  logic                  end_of_string,
  output logic                  q_push,
  output utf8vg_pkg::entry_t    q_word
);
  import utf8vg_pkg::*;

  logic [7:0] pending_lead, pending_lead_next;
  logic [1:0] need, need_next;
  logic [7:0] held_cont, held_cont_next;

  always_comb begin
    pending_lead_next = pending_lead;
    need_next         = need;
    held_cont_next    = held_cont;
    q_push            = 1'b0;
    q_word            = '{cp: CP_QM, last: end_of_string, dbl: 1'b0};

    if (need == 2'd1) begin
      q_push    = 1'b1;
      need_next = 2'd0;
      if (pending_lead[7:5] == 3'b110) begin
        q_word.cp = {5'd0, pending_lead[4:0], text_byte[5:0]};
      end else begin
        q_word.cp = {pending_lead[3:0], held_cont[5:0], text_byte[5:0]};
      end
    end else if (need == 2'd2) begin
      if (end_of_string) begin
        // lead gives '?', the final byte is then a lead of its own
        q_push      = 1'b1;
        need_next   = 2'd0;
        q_word.dbl  = 1'b1;
        q_word.cp   = text_byte[7] ? CP_QM : {8'd0, text_byte};
      end else begin
        held_cont_next = text_byte;
        need_next      = 2'd1;
      end
    end else begin
      need_next = 2'd0;
      if (!text_byte[7]) begin
        q_push    = 1'b1;
        q_word.cp = {8'd0, text_byte};
      end else if (text_byte[7:5] == 3'b110 && !end_of_string) begin
        pending_lead_next = text_byte;
        need_next         = 2'd1;
      end else if (text_byte[7:4] == 4'b1110 && !end_of_string) begin
        pending_lead_next = text_byte;
        need_next         = 2'd2;
      end else begin
        q_push = 1'b1;
      end
    end

    if (end_of_string) begin
      pending_lead_next = 8'd0;
      need_next         = 2'd0;
      held_cont_next    = 8'd0;
    end

    if (!accept) begin
      q_push = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_lead <= 8'd0;
      need         <= 2'd0;
      held_cont    <= 8'd0;
    end else if (accept) begin
      pending_lead <= pending_lead_next;
      need         <= need_next;
      held_cont    <= held_cont_next;
    end
  end

endmodule

// ===== rtl/utf8vg_queue.sv =====
// ----------------------------------------------------------------------------
// utf8vg_queue
// Small register queue between the classifier and the glyph stage.
// ----------------------------------------------------------------------------
module utf8vg_queue #(
  parameter int unsigned DEPTH = utf8vg_pkg::QueueDepthDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  utf8vg_pkg::entry_t    wdata,
  output logic                  full,
  output logic                  valid,
  input  logic                  pop,
  output utf8vg_pkg::entry_t    rdata
);
  import utf8vg_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PtrLast = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CntFull = CW'(DEPTH);

  entry_t        slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign full    = (count == CntFull);
  assign valid   = (count != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/utf8vg_back.sv =====
// ----------------------------------------------------------------------------
// utf8vg_back
// Glyph stage: table lookup, column and width, registered result word.
// ----------------------------------------------------------------------------
module utf8vg_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [3:0]            pitch,
  input  logic                  q_valid,
  input  utf8vg_pkg::entry_t    q_word,
  output logic                  q_pop,
  output logic                  empty,
  input  logic                  pop,
  output logic [6:0]            base_char,
  output logic [8:0]            mark_bits,
  output logic [15:0]           column_offset,
  output logic                  final_glyph,
  output logic [15:0]           string_width
);
  import utf8vg_pkg::*;

  logic        out_valid;
  logic        phase;        // first half of a split word already sent
  logic [15:0] glyph_count;
  logic [15:0] count_inc;
  logic        take, first_half, is_last;
  glyph_t      g;

  assign empty      = !out_valid;
  assign take       = q_valid && (!out_valid || pop);
  assign first_half = q_word.dbl && !phase;
  assign is_last    = q_word.last && !first_half;
  assign q_pop      = take && !first_half;
  assign count_inc  = (glyph_count == SAT16) ? SAT16 : glyph_count + 16'd1;
  assign g          = map_cp(first_half ? CP_QM : q_word.cp);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      phase       <= 1'b0;
      glyph_count <= 16'd0;
    end else begin
      if (take) begin
        out_valid   <= 1'b1;
        phase       <= first_half;
        glyph_count <= is_last ? 16'd0 : count_inc;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      base_char     <= g.base;
      mark_bits     <= g.marks;
      column_offset <= sat_mul(glyph_count, pitch);
      final_glyph   <= is_last;
      string_width  <= is_last ? sat_mul(count_inc, pitch) : 16'd0;
    end
  end

endmodule

// ===== rtl/utf8_vietnamese_glyph_decoder.sv =====
// ----------------------------------------------------------------------------
// utf8_vietnamese_glyph_decoder
// UTF-8 byte stream to ASCII base character plus Vietnamese diacritic bits.
// ----------------------------------------------------------------------------
// One byte is taken per cycle while the queue is not full. The byte completing a
// glyph is written into the word queue, and the glyph is then registered in the
// result register. A three-byte sequence cut short by the end of the string
// yields two glyphs from one queue word, keeping the glyph stage busy for both;
// the classifier keeps taking bytes meanwhile until the QUEUE_DEPTH word queue
// between the two halves fills. The single result register is refilled in the
// cycle it is popped, so a consumer popping every cycle sees one glyph per cycle while the queue holds words.
module utf8_vietnamese_glyph_decoder #(
  parameter int unsigned QUEUE_DEPTH = utf8vg_pkg::QueueDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  text_byte,
  input  logic        end_of_string,
  output logic        empty,
  input  logic        pop,
  output logic [6:0]  base_char,
  output logic [8:0]  mark_bits,
  output logic [15:0] column_offset,
  output logic        final_glyph,
  output logic [15:0] string_width
);
  import utf8vg_pkg::*;

  logic [3:0] glyph_pitch;
  logic       accept;
  logic       q_push, q_valid, q_pop;
  entry_t     q_wdata, q_rdata;

  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_pitch <= PitchReset;
    end else if (cfg_we) begin
      glyph_pitch <= cfg_data;
    end
  end

  utf8vg_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .text_byte     (text_byte),
    .end_of_string (end_of_string),
    .q_push        (q_push),
    .q_word        (q_wdata)
  );

  utf8vg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (full),
    .valid (q_valid),
    .pop   (q_pop),
    .rdata (q_rdata)
  );

  utf8vg_back u_back (
    .clk           (clk),
    .rst           (rst),
    .pitch         (glyph_pitch),
    .q_valid       (q_valid),
    .q_word        (q_rdata),
    .q_pop         (q_pop),
    .empty         (empty),
    .pop           (pop),
    .base_char     (base_char),
    .mark_bits     (mark_bits),
    .column_offset (column_offset),
    .final_glyph   (final_glyph),
    .string_width  (string_width)
  );

  // width is only carried on the last glyph of a string
  a_width_only_final: assert property (@(posedge clk) disable iff (rst)
    (!empty && !final_glyph) |-> (string_width == 16'd0))
    else $error("string width on a non-final glyph");

  a_width_covers_column: assert property (@(posedge clk) disable iff (rst)
    (!empty && final_glyph) |-> (string_width >= column_offset))
    else $error("string width below column of final glyph");

  // a full queue means the glyph stage already holds a word
  a_full_implies_output: assert property (@(posedge clk) disable iff (rst)
    full |-> !empty)
    else $error("queue full while result register is empty");

endmodule
